### rtl/core/gope_pkg.sv
// shared types and constants for the gaussian orbital point evaluator
// no dependencies; used by gaussian_orbital_point_eval
package gope_pkg;

  localparam int MAX_POWER_DEF = 6;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SERIES_TERMS  = 10;

  localparam logic [26:0] LOG2E_FRAC_Q28 = 27'd118835045;
  localparam logic [31:0] LN2_Q32        = 32'hB17217F8;
  localparam logic [31:0] HALF_ROOT_Q32  = 32'hB504F334;

  typedef enum logic [2:0] {
    REG_ALPHA,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_POWER_X,
    REG_POWER_Y,
    REG_POWER_Z,
    REG_NORM
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] orbital_value;
    logic               saturated;
  } out_t;

endpackage

### rtl/core/gaussian_orbital_point_eval.sv
// throughput: one transaction per cycle unless the output buffer is full and out_ready is low
// each multiply sits in its own pipeline stage
// the exp series takes three stages per term, each mantissa multiply three stages
// a two-entry output buffer keeps input flowing while a result waits
// reset: synchronous active-low rst_n clears valid bits, buffer count and configuration registers
// depends on gope_pkg
module gaussian_orbital_point_eval #(
  parameter int MAX_POWER = gope_pkg::MAX_POWER_DEF,
  parameter int FRAC_BITS = gope_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gope_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gope_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int PMAX  = (MAX_POWER < 7) ? MAX_POWER : 7;
  localparam int NS    = 1 + 3 * PMAX;
  localparam int SW    = 66 - FRAC_BITS;
  localparam int SHW   = SW - 32;
  localparam int TW    = FRAC_BITS + 7;
  localparam int UW    = TW + 1;
  localparam int KW    = UW - FRAC_BITS;
  localparam int EW    = $clog2((33 + FRAC_BITS) * (NS + 1)) + 2;
  localparam int NT    = gope_pkg::SERIES_TERMS;
  localparam int NSER  = 3 * NT;
  localparam int ST_SQ = 1;
  localparam int ST_S  = 2;
  localparam int ST_P  = 3;
  localparam int ST_T  = 4;
  localparam int ST_TM = 5;
  localparam int ST_U  = 6;
  localparam int ST_Y  = 7;
  localparam int SB    = 8;
  localparam int ST_G  = SB + NSER;
  localparam int ST_E  = ST_G + 1;
  localparam int MB    = ST_E + 1;
  localparam int ST_R  = MB + 3 * NS;
  localparam int NSTG  = ST_R + 1;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
  } ctx_t;

  // configuration registers
  logic [31:0] alpha_r, cx_r, cy_r, cz_r, norm_r;
  logic [2:0]  pwx_r, pwy_r, pwz_r;
  logic [2:0]  pwx_c, pwy_c, pwz_c;
  gope_pkg::reg_idx_t reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = gope_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      cz_r    <= '0;
      pwx_r   <= '0;
      pwy_r   <= '0;
      pwz_r   <= '0;
      norm_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        gope_pkg::REG_ALPHA:    alpha_r <= pwdata;
        gope_pkg::REG_CENTER_X: cx_r    <= pwdata;
        gope_pkg::REG_CENTER_Y: cy_r    <= pwdata;
        gope_pkg::REG_CENTER_Z: cz_r    <= pwdata;
        gope_pkg::REG_POWER_X:  pwx_r   <= pwdata[2:0];
        gope_pkg::REG_POWER_Y:  pwy_r   <= pwdata[2:0];
        gope_pkg::REG_POWER_Z:  pwz_r   <= pwdata[2:0];
        gope_pkg::REG_NORM:     norm_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gope_pkg::REG_ALPHA:    prdata = alpha_r;
      gope_pkg::REG_CENTER_X: prdata = cx_r;
      gope_pkg::REG_CENTER_Y: prdata = cy_r;
      gope_pkg::REG_CENTER_Z: prdata = cz_r;
      gope_pkg::REG_POWER_X:  prdata = {29'b0, pwx_r};
      gope_pkg::REG_POWER_Y:  prdata = {29'b0, pwy_r};
      gope_pkg::REG_POWER_Z:  prdata = {29'b0, pwz_r};
      gope_pkg::REG_NORM:     prdata = norm_r;
      default:                prdata = '0;
    endcase
  end

  assign pwx_c = (int'(pwx_r) > MAX_POWER) ? 3'(MAX_POWER) : pwx_r;
  assign pwy_c = (int'(pwy_r) > MAX_POWER) ? 3'(MAX_POWER) : pwy_r;
  assign pwz_c = (int'(pwz_r) > MAX_POWER) ? 3'(MAX_POWER) : pwz_r;

  // pipeline control
  logic       v_r [0:NSTG-1];
  ctx_t       ctx_r [0:NSTG-1];
  logic [1:0] ocnt_r;
  logic       adv, push, pop;

  assign adv      = !v_r[ST_R] || (ocnt_r != 2'd2) || out_ready;
  assign in_ready = adv;
  assign push     = adv && v_r[ST_R];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) v_r[i] <= v_r[i-1];
    end
  end

  // offsets from center
  logic [32:0] dx, dy, dz;
  ctx_t        ctx_nxt;

  always_comb begin
    dx = {in_data.point_x[31], in_data.point_x} - {cx_r[31], cx_r};
    dy = {in_data.point_y[31], in_data.point_y} - {cy_r[31], cy_r};
    dz = {in_data.point_z[31], in_data.point_z} - {cz_r[31], cz_r};
    ctx_nxt.mag_x = dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
    ctx_nxt.mag_y = dy[32] ? 32'(~dy + 33'd1) : dy[31:0];
    ctx_nxt.mag_z = dz[32] ? 32'(~dz + 33'd1) : dz[31:0];
    ctx_nxt.neg   = (dx[32] & pwx_c[0]) ^ (dy[32] & pwy_c[0]) ^ (dz[32] & pwz_c[0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[0] <= ctx_nxt;
      for (int i = 1; i < NSTG; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  // squared distance and scaled exponent argument
  logic [63:0]      sqr_r [0:2];
  logic [SW-1:0]    s_r, s_nxt;
  logic [63:0]      plo_r;
  logic [31+SHW:0]  phi_r;
  logic [63:0]      tcap, tsum;
  logic             phi_sat;
  logic [TW-1:0]    t_r, t_nxt, t2_r;
  logic [TW+26:0]   tm_r;
  logic [UW-1:0]    u;
  logic [KW-1:0]    kfull;
  logic [FRAC_BITS-2:0] q_r;
  logic [6:0]       hk_r, hk2_r, hk_nxt;
  logic [30:0]      y_r, y_nxt;

  assign s_nxt = SW'(sqr_r[0] >> FRAC_BITS) + SW'(sqr_r[1] >> FRAC_BITS)
               + SW'(sqr_r[2] >> FRAC_BITS);

  always_comb begin
    tcap    = 64'd1 << (FRAC_BITS + 6);
    phi_sat = 64'(phi_r) >= tcap;
    tsum    = (64'(phi_r) << (32 - FRAC_BITS)) + (plo_r >> FRAC_BITS);
    t_nxt   = (phi_sat || tsum > tcap) ? TW'(tcap) : TW'(tsum);
  end

  always_comb begin
    u      = UW'(t2_r) + UW'(tm_r >> 28);
    kfull  = u[UW-1:FRAC_BITS];
    hk_nxt = {kfull >= KW'(32), u[FRAC_BITS-1], kfull[4:0]};
    y_nxt  = 31'((64'({q_r, {(32 - FRAC_BITS){1'b0}}}) * 64'(gope_pkg::LN2_Q32)) >> 32);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqr_r[0] <= 64'(ctx_r[ST_SQ-1].mag_x) * 64'(ctx_r[ST_SQ-1].mag_x);
      sqr_r[1] <= 64'(ctx_r[ST_SQ-1].mag_y) * 64'(ctx_r[ST_SQ-1].mag_y);
      sqr_r[2] <= 64'(ctx_r[ST_SQ-1].mag_z) * 64'(ctx_r[ST_SQ-1].mag_z);
      s_r      <= s_nxt;
      plo_r    <= 64'(alpha_r) * 64'(s_r[31:0]);
      phi_r    <= (32 + SHW)'(alpha_r) * (32 + SHW)'(s_r[SW-1:32]);
      t_r      <= t_nxt;
      tm_r     <= (TW + 27)'(t_r) * (TW + 27)'(gope_pkg::LOG2E_FRAC_Q28);
      t2_r     <= t_r;
      q_r      <= u[FRAC_BITS-2:0];
      hk_r     <= hk_nxt;
      y_r      <= y_nxt;
      hk2_r    <= hk_r;
    end
  end

  // exp series, three stages per term
  logic [30:0] sy_r [0:NSER-1];
  logic [32:0] ss_r [0:NSER-1];
  logic [6:0]  sk_r [0:NSER-1];
  logic [30:0] sx_r [1:NT];
  logic [30:0] sxd_r [1:NT];
  logic [30:0] sqe_r [1:NT];
  logic [32:0] sterm_r [1:NT];
  logic [32:0] ssum_nxt [1:NT];

  for (genvar j = 0; j < NSER; j++) begin : g_ser_pass
    logic [30:0] y_in;
    logic [32:0] s_in;
    logic [6:0]  k_in;
    if (j == 0) begin : g_first
      assign y_in = y_r;
      assign s_in = ONE_Q32;
      assign k_in = hk2_r;
    end else begin : g_next
      assign y_in = sy_r[j-1];
      assign s_in = ss_r[j-1];
      assign k_in = sk_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sy_r[j] <= y_in;
        sk_r[j] <= k_in;
        if ((j % 3) == 2) begin
          ss_r[j] <= ssum_nxt[(j / 3) + 1];
        end else begin
          ss_r[j] <= s_in;
        end
      end
    end
  end

  for (genvar n = 1; n <= NT; n++) begin : g_term
    localparam int          J     = 3 * (n - 1);
    localparam bit          POW2  = (n & (n - 1)) == 0;
    localparam int          LG    = $clog2(n);
    localparam logic [34:0] RECIP = 35'((64'd1 << 35) / n);
    logic [32:0] t_in;
    logic [30:0] yv;
    logic [34:0] rem;
    logic [30:0] term_v;
    if (n == 1) begin : g_first
      assign t_in = ONE_Q32;
      assign yv   = y_r;
    end else begin : g_next
      assign t_in = sterm_r[n-1];
      assign yv   = sy_r[J-1];
    end
    always_comb begin
      rem    = 35'(sxd_r[n]) - 35'(sqe_r[n]) * 35'(n);
      term_v = (!POW2 && rem >= 35'(n)) ? sqe_r[n] + 31'd1 : sqe_r[n];
      if ((n % 2) == 1) begin
        ssum_nxt[n] = ss_r[J+1] - 33'(term_v);
      end else begin
        ssum_nxt[n] = ss_r[J+1] + 33'(term_v);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sx_r[n]    <= 31'((64'(t_in) * 64'(yv)) >> 32);
        sxd_r[n]   <= sx_r[n];
        sqe_r[n]   <= POW2 ? (sx_r[n] >> LG)
                           : 31'((66'(sx_r[n]) * 66'(RECIP)) >> 35);
        sterm_r[n] <= 33'(term_v);
      end
    end
  end

  // table step and integer shift
  logic [32:0] g_r, g_nxt, ex_r, ex_nxt;
  logic [5:0]  gk_r;

  assign g_nxt  = sk_r[NSER-1][5]
                ? 33'((65'(ss_r[NSER-1]) * 65'(gope_pkg::HALF_ROOT_Q32)) >> 32)
                : ss_r[NSER-1];
  assign ex_nxt = gk_r[5] ? 33'd0 : (g_r >> gk_r[4:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r  <= g_nxt;
      gk_r <= {sk_r[NSER-1][6], sk_r[NSER-1][4:0]};
      ex_r <= ex_nxt;
    end
  end

  // mantissa/exponent product chain
  logic [63:0]          mp_r  [0:NS-1];
  logic [63:0]          mp2_r [0:NS-1];
  logic [5:0]           mc_r  [0:NS-1];
  logic [31:0]          mm_r  [0:NS-1];
  logic signed [EW-1:0] me1_r [0:NS-1];
  logic signed [EW-1:0] me2_r [0:NS-1];
  logic signed [EW-1:0] me3_r [0:NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_slot
    localparam int B = MB + 3 * j;
    logic [32:0]          f;
    logic signed [EW-1:0] sh;
    logic [31:0]          m_in;
    logic signed [EW-1:0] e_in;
    logic [5:0]           cnt_nxt;
    if (j == 0) begin : g_first
      assign f    = ex_r;
      assign sh   = EW'(32);
      assign m_in = norm_r;
      assign e_in = '0;
    end else begin : g_next
      logic [4:0] pa, pb, pc;
      assign pa   = 5'(pwx_c);
      assign pb   = pa + 5'(pwy_c);
      assign pc   = pb + 5'(pwz_c);
      assign m_in = mm_r[j-1];
      assign e_in = me3_r[j-1];
      always_comb begin
        if (5'(j) <= pa) begin
          f  = 33'(ctx_r[B-1].mag_x);
          sh = EW'(FRAC_BITS);
        end else if (5'(j) <= pb) begin
          f  = 33'(ctx_r[B-1].mag_y);
          sh = EW'(FRAC_BITS);
        end else if (5'(j) <= pc) begin
          f  = 33'(ctx_r[B-1].mag_z);
          sh = EW'(FRAC_BITS);
        end else begin
          f  = 33'd1;
          sh = '0;
        end
      end
    end
    always_comb begin
      cnt_nxt = '0;
      for (int b = 0; b < 32; b++) begin
        if (mp_r[j][32+b]) cnt_nxt = 6'(b + 1);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        mp_r[j]  <= 64'(m_in) * 64'(f);
        me1_r[j] <= e_in - sh;
        mc_r[j]  <= cnt_nxt;
        mp2_r[j] <= mp_r[j];
        me2_r[j] <= me1_r[j];
        mm_r[j]  <= 32'(mp2_r[j] >> mc_r[j]);
        me3_r[j] <= me2_r[j] + EW'(mc_r[j]);
      end
    end
  end

  // scale back to fixed point
  logic [63:0]          res_r, res_nxt;
  logic                 satf_r, satf_nxt;
  logic [31:0]          fm;
  logic signed [EW-1:0] fe, fe_neg;

  always_comb begin
    fm       = mm_r[NS-1];
    fe       = me3_r[NS-1];
    fe_neg   = -fe;
    res_nxt  = '0;
    satf_nxt = 1'b0;
    if (fm != '0) begin
      if (fe >= EW'(32)) begin
        satf_nxt = 1'b1;
      end else if (fe >= 0) begin
        res_nxt = 64'(fm) << fe[4:0];
      end else if (fe > -EW'(64)) begin
        res_nxt = 64'(fm) >> fe_neg[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      satf_r <= satf_nxt;
    end
  end

  // clip, sign and output buffer
  logic [63:0]    limit;
  logic           clip;
  logic [31:0]    mag32;
  gope_pkg::out_t item_nxt;
  gope_pkg::out_t ob_r [0:1];

  always_comb begin
    limit                  = ctx_r[ST_R].neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    clip                   = satf_r || (res_r > limit);
    mag32                  = clip ? limit[31:0] : res_r[31:0];
    item_nxt.orbital_value = ctx_r[ST_R].neg ? -mag32 : mag32;
    item_nxt.saturated     = clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
    end else begin
      ocnt_r <= ocnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (ocnt_r == 2'd0) ob_r[0] <= item_nxt;
        else ob_r[1] <= item_nxt;
      end
      2'b01: begin
        ob_r[0] <= ob_r[1];
      end
      2'b11: begin
        if (ocnt_r == 2'd1) begin
          ob_r[0] <= item_nxt;
        end else begin
          ob_r[0] <= ob_r[1];
          ob_r[1] <= item_nxt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ocnt_r != 2'd0;
  assign out_data  = ob_r[0];

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ocnt_r == 2'd2) && v_r[ST_R])
    else $error("input stalled without a full output buffer");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.orbital_value == 32'sh7FFF_FFFF) || (out_data.orbital_value == 32'sh8000_0000))
    else $error("saturated result not at a limit");

  a_series_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_G-1] |-> ss_r[NSER-1] <= ONE_Q32)
    else $error("exp series sum above one");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_E] |-> ex_r <= ONE_Q32)
    else $error("exponential above one");
`endif

endmodule

### bench/testbench.sv
// self-checking testbench for gaussian_orbital_point_eval
// predicts each orbital value in fixed point and checks it against the block's output
// depends on gope_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;

  localparam int FB   = gope_pkg::FRAC_BITS_DEF;
  localparam int PMAX = gope_pkg::MAX_POWER_DEF;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  gope_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  gope_pkg::out_t out_data;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gaussian_orbital_point_eval uut (.*);

  always #2 clk = ~clk;

  logic [31:0] alpha_q, norm_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [2:0] px_q, py_q, pz_q;

  gope_pkg::in_t points_q[$];
  gope_pkg::out_t orbitals_q[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_zero = 0;
  int n_phases = 0;
  bit hold_go = 0;

  function automatic gope_pkg::out_t predict_orbital(gope_pkg::in_t pt);
    longint signed d[3];
    longint unsigned mag[3];
    longint unsigned s, s_lo, s_hi, p_lo, p_hi, t, u, k, frac, q, y, term, g, ex;
    longint unsigned m, p, f, res, lim;
    longint signed acc;
    int pw[3];
    int e, sh, reps;
    bit neg, sat;
    gope_pkg::out_t r;
    d[0] = longint'(pt.point_x) - longint'(cx_q);
    d[1] = longint'(pt.point_y) - longint'(cy_q);
    d[2] = longint'(pt.point_z) - longint'(cz_q);
    pw[0] = (px_q > PMAX) ? PMAX : px_q;
    pw[1] = (py_q > PMAX) ? PMAX : py_q;
    pw[2] = (pz_q > PMAX) ? PMAX : pz_q;
    s = 0;
    neg = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      s += (mag[i] * mag[i]) >> FB;
      if (d[i] < 0 && pw[i][0]) neg = ~neg;
    end
    s_lo = s & 64'hFFFF_FFFF;
    s_hi = s >> 32;
    p_lo = longint'(alpha_q) * s_lo;
    p_hi = longint'(alpha_q) * s_hi;
    if (p_hi >= (64'd64 << FB)) t = 64'd64 << FB;
    else begin
      t = (p_hi << (32 - FB)) + (p_lo >> FB);
      if (t > (64'd64 << FB)) t = 64'd64 << FB;
    end
    // exp(-t) by base-2 range reduction and a short series
    u = t + ((t * 64'(gope_pkg::LOG2E_FRAC_Q28)) >> 28);
    k = u >> FB;
    if (k >= 32) ex = 0;
    else begin
      frac = u & ((64'd1 << FB) - 1);
      q = frac & ((64'd1 << (FB - 1)) - 1);
      y = ((q << (32 - FB)) * 64'(gope_pkg::LN2_Q32)) >> 32;
      term = 64'd1 << 32;
      acc = longint'(term);
      for (int n = 1; n <= gope_pkg::SERIES_TERMS; n++) begin
        term = ((term * y) >> 32) / n;
        if (n % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      g = acc;
      if (frac >> (FB - 1)) g = (g * 64'(gope_pkg::HALF_ROOT_Q32)) >> 32;
      ex = g >> k;
    end
    m = norm_q;
    e = 0;
    for (int i = 0; i < 4; i++) begin
      reps = (i == 0) ? 1 : pw[i-1];
      f = (i == 0) ? ex : mag[i-1];
      sh = (i == 0) ? 32 : FB;
      for (int j = 0; j < reps; j++) begin
        p = m * f;
        e -= sh;
        while (p > 64'hFFFF_FFFF) begin
          p >>= 1;
          e++;
        end
        m = p;
      end
    end
    res = 0;
    sat = 0;
    if (m != 0) begin
      if (e >= 32) sat = 1;
      else if (e >= 0) res = m << e;
      else if (e > -64) res = m >> (-e);
    end
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (sat || res > lim) begin
      res = lim;
      sat = 1;
    end
    if (neg) res = (64'd0 - res) & 64'hFFFF_FFFF;
    r.orbital_value = res[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (in_valid && in_ready) begin
      orbitals_q.push_back(predict_orbital(in_data));
      nv = 0;
    end
    if (rst_n && !nv) begin
      if (gap_left > 0) gap_left--;
      else if (points_q.size() > 0) begin
        in_data <= points_q.pop_front();
        nv = 1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: own stall pattern plus one long hold-off
  int stall_left = 0;
  int run_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    logic nr;
    nr = 1;
    if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      nr = 0;
    end else if (run_left > 0) run_left--;
    else begin
      run_left = $urandom_range(0, 4) == 0 ? 150 : $urandom_range(0, 8);
      stall_left = $urandom_range(0, 5);
    end
    out_ready <= nr;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0h expected %0h", what, got, want);
    n_errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    gope_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (orbitals_q.size() == 0) report_mismatch("unexpected transaction", out_data, 0);
      else begin
        want = orbitals_q.pop_front();
        n_checked++;
        if (want.saturated) n_sat++;
        if (want.orbital_value == 0) n_zero++;
        if (out_data.orbital_value !== want.orbital_value)
          report_mismatch("orbital_value", out_data.orbital_value, want.orbital_value);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
      end
    end
  end

  task automatic write_reg(gope_pkg::reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      gope_pkg::REG_ALPHA: alpha_q = v;
      gope_pkg::REG_CENTER_X: cx_q = v;
      gope_pkg::REG_CENTER_Y: cy_q = v;
      gope_pkg::REG_CENTER_Z: cz_q = v;
      gope_pkg::REG_POWER_X: px_q = v[2:0];
      gope_pkg::REG_POWER_Y: py_q = v[2:0];
      gope_pkg::REG_POWER_Z: pz_q = v[2:0];
      gope_pkg::REG_NORM: norm_q = v;
      default: ;
    endcase
  endtask

  task automatic set_orbital(logic [31:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [2:0] ppx, logic [2:0] ppy, logic [2:0] ppz,
                             logic [31:0] nf);
    write_reg(gope_pkg::REG_ALPHA, a);
    write_reg(gope_pkg::REG_CENTER_X, x);
    write_reg(gope_pkg::REG_CENTER_Y, y);
    write_reg(gope_pkg::REG_CENTER_Z, z);
    write_reg(gope_pkg::REG_POWER_X, ppx);
    write_reg(gope_pkg::REG_POWER_Y, ppy);
    write_reg(gope_pkg::REG_POWER_Z, ppz);
    write_reg(gope_pkg::REG_NORM, nf);
    n_phases++;
  endtask

  task automatic drain();
    while (points_q.size() > 0 || in_valid || orbitals_q.size() > 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic gope_pkg::in_t near_point(int spread);
    gope_pkg::in_t pt;
    pt.point_x = cx_q + $signed($urandom_range(0, 2 * spread)) - spread;
    pt.point_y = cy_q + $signed($urandom_range(0, 2 * spread)) - spread;
    pt.point_z = cz_q + $signed($urandom_range(0, 2 * spread)) - spread;
    return pt;
  endfunction

  function automatic gope_pkg::in_t any_point();
    gope_pkg::in_t pt;
    pt.point_x = $urandom;
    pt.point_y = $urandom;
    pt.point_z = $urandom;
    return pt;
  endfunction

  task automatic random_points(int count);
    int spread;
    for (int i = 0; i < count; i++) begin
      spread = 1 << $urandom_range(8, 19);
      points_q.push_back($urandom_range(0, 4) == 0 ? any_point() : near_point(spread));
    end
  endtask

  initial begin
    gope_pkg::in_t pt;
    alpha_q = 0; cx_q = 0; cy_q = 0; cz_q = 0;
    px_q = 0; py_q = 0; pz_q = 0; norm_q = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // reset values: everything evaluates to zero
    points_q.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 0});
    points_q.push_back('{0, 0, 0});
    drain();
    // directed: extremes, zero offsets, clamped powers, overflow, tiny values
    set_orbital(32'h0001_0000, 0, 0, 0, 1, 2, 3, 32'h0001_0000);
    points_q.push_back('{0, 0, 0});
    points_q.push_back('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    points_q.push_back('{-32'sh0001_0000, 32'sh0000_8000, -32'sh0002_0000});
    points_q.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    points_q.push_back('{32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0001});
    drain();
    set_orbital(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 7, 7, 7, 32'hFFFF_FFFF);
    points_q.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0004_0000});
    points_q.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 0});
    points_q.push_back('{32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh0000_0100});
    points_q.push_back('{0, 0, -32'sh0004_0000});
    drain();
    set_orbital(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF);
    points_q.push_back('{0, 0, 0});
    points_q.push_back('{0, 0, -32'sh0000_0010});
    points_q.push_back('{32'sh0000_0100, 0, 32'sh0000_0100});
    points_q.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    drain();
    set_orbital(32'h0000_0100, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
    points_q.push_back('{0, 0, 0});
    points_q.push_back('{32'sh0010_0000, 32'sh0010_0000, 0});
    points_q.push_back('{32'sh0100_0000, 0, 0});
    drain();
    // random orbitals with points mostly near the center
    for (int ph = 0; ph < 9; ph++) begin
      set_orbital($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 18),
                  $urandom_range(0, 4) == 0 ? $urandom : $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                  $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                  $urandom_range(0, 4) == 0 ? $urandom : $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                  $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1 << 20));
      random_points(72);
      if (ph == 4) hold_go = 1;
      drain();
    end
    $display("checked %0d orbital values over %0d register settings", n_checked, n_phases);
    $display("%0d saturated, %0d flushed to zero", n_sat, n_zero);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### gaussian_orbital_point_eval.f
rtl/core/gope_pkg.sv
rtl/core/gaussian_orbital_point_eval.sv
bench/testbench.sv
